// File: sv/pid_controller_integral_separation_macros.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Small wrappers that keep the clock, reset and reporting of each check uniform.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_CONTROLLER_INTEGRAL_SEPARATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pid_is_pkg.sv
// ----------------------------------------------------------------------------
// pid_is_pkg
// Widths, register indexes and the configuration record of the PID controller.
// ----------------------------------------------------------------------------
package pid_is_pkg;

  // Fraction bits of the Q8.8 gains.
  localparam int GAIN_FRAC_BITS = 8;

  // Field widths.
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int BAND_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 17;
  localparam int DRIVE_W  = 16;
  localparam int CFG_W    = 16;

  // Internal datapath widths.
  localparam int ERR_W   = SAMPLE_W + 1;       // target - measure
  localparam int INTEG_W = 16;                 // stored integral
  localparam int ISUM_W  = ERR_W + 1;          // integral plus error
  localparam int DERIV_W = ERR_W + 1;          // error difference
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + INTEG_W;
  localparam int PD_W    = GAIN_W + DERIV_W;
  localparam int ACC_W   = PD_W + 2;
  localparam int Q_W     = ACC_W - GAIN_FRAC_BITS;

  // Register indexes on the configuration port.
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_INTEGRAL_LIMIT  = 3'd3,
    REG_OUTPUT_LIMIT    = 3'd4,
    REG_SEPARATION_BAND = 3'd5,
    REG_DERIV_SOURCE    = 3'd6
  } reg_idx_t;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
    logic [BAND_W-1:0]  separation_band;
    logic               derivative_source;
  } cfg_t;

  // Load strobes for the datapath stages.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } pipe_ctl_t;

endpackage

// File: sv/pid_is_cfg.sv
// ----------------------------------------------------------------------------
// pid_is_cfg
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module pid_is_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pid_is_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pid_is_pkg::CFG_W-1:0]        cfg_data,
  output pid_is_pkg::cfg_t                    cfg
);

  pid_is_pkg::cfg_t regs;

  // Decode the index and update one register; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      unique case (pid_is_pkg::reg_idx_t'(cfg_index))
        pid_is_pkg::REG_GAIN_P: begin
          regs.gain_p <= cfg_data[pid_is_pkg::GAIN_W-1:0];
        end
        pid_is_pkg::REG_GAIN_I: begin
          regs.gain_i <= cfg_data[pid_is_pkg::GAIN_W-1:0];
        end
        pid_is_pkg::REG_GAIN_D: begin
          regs.gain_d <= cfg_data[pid_is_pkg::GAIN_W-1:0];
        end
        pid_is_pkg::REG_INTEGRAL_LIMIT: begin
          regs.integral_limit <= cfg_data[pid_is_pkg::LIMIT_W-1:0];
        end
        pid_is_pkg::REG_OUTPUT_LIMIT: begin
          regs.output_limit <= cfg_data[pid_is_pkg::LIMIT_W-1:0];
        end
        pid_is_pkg::REG_SEPARATION_BAND: begin
          regs.separation_band <= cfg_data[pid_is_pkg::BAND_W-1:0];
        end
        pid_is_pkg::REG_DERIV_SOURCE: begin
          regs.derivative_source <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: sv/pid_is_state.sv
// ----------------------------------------------------------------------------
// pid_is_state
// Error, separated and clamped integral, and derivative for one sample.
// Holds the controller state, which advances as each sample leaves stage 1.
// ----------------------------------------------------------------------------
module pid_is_state (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      ld2,
  input  pid_is_pkg::cfg_t                          cfg,
  input  logic signed [pid_is_pkg::SAMPLE_W-1:0]    tgt,
  input  logic signed [pid_is_pkg::SAMPLE_W-1:0]    mea,
  input  logic signed [pid_is_pkg::RATE_W-1:0]      rate,
  output logic signed [pid_is_pkg::ERR_W-1:0]       err2,
  output logic signed [pid_is_pkg::INTEG_W-1:0]     integ2,
  output logic signed [pid_is_pkg::DERIV_W-1:0]     deriv2
);

  logic signed [pid_is_pkg::ERR_W-1:0]   previous_error;
  logic signed [pid_is_pkg::INTEG_W-1:0] error_integral;

  logic signed [pid_is_pkg::ERR_W-1:0]   err_c;
  logic        [pid_is_pkg::ERR_W-1:0]   mag_c;
  logic signed [pid_is_pkg::ISUM_W-1:0]  isum_c;
  logic signed [pid_is_pkg::ISUM_W-1:0]  ilim_c;
  logic signed [pid_is_pkg::ISUM_W-1:0]  iclamp_c;
  logic signed [pid_is_pkg::DERIV_W-1:0] deriv_c;
  logic                                  separate_c;

  // Error and its magnitude.
  always_comb begin
    err_c = pid_is_pkg::ERR_W'(tgt) - pid_is_pkg::ERR_W'(mea);
    mag_c = err_c[pid_is_pkg::ERR_W-1] ? pid_is_pkg::ERR_W'(-err_c) : err_c;
  end

  // Integral: accumulate, zero outside the band, then clamp symmetrically.
  always_comb begin
    separate_c = (cfg.separation_band != '0) &&
                 (mag_c > pid_is_pkg::ERR_W'(cfg.separation_band));
    isum_c = separate_c ? '0 :
             pid_is_pkg::ISUM_W'(error_integral) + pid_is_pkg::ISUM_W'(err_c);
    ilim_c = $signed(pid_is_pkg::ISUM_W'(cfg.integral_limit));
    if (isum_c >= ilim_c) begin
      iclamp_c = ilim_c;
    end else if (isum_c <= -ilim_c) begin
      iclamp_c = -ilim_c;
    end else begin
      iclamp_c = isum_c;
    end
  end

  // Derivative from the error difference or from the external rate.
  always_comb begin
    if (cfg.derivative_source) begin
      deriv_c = pid_is_pkg::DERIV_W'(rate);
    end else begin
      deriv_c = pid_is_pkg::DERIV_W'(err_c) - pid_is_pkg::DERIV_W'(previous_error);
    end
  end

  // Controller state advances only when the sample moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (ld2) begin
      previous_error <= err_c;
      error_integral <= iclamp_c[pid_is_pkg::INTEG_W-1:0];
    end
  end

  // Stage 2 result registers.
  always_ff @(posedge clk) begin
    if (ld2) begin
      err2   <= err_c;
      integ2 <= iclamp_c[pid_is_pkg::INTEG_W-1:0];
      deriv2 <= deriv_c;
    end
  end

endmodule

// File: sv/pid_is_mac.sv
// ----------------------------------------------------------------------------
// pid_is_mac
// Gain products, their sum, the floor shift and the output saturation.
// ----------------------------------------------------------------------------
module pid_is_mac (
  input  logic                                      clk,
  input  pid_is_pkg::pipe_ctl_t                     ctl,
  input  pid_is_pkg::cfg_t                          cfg,
  input  logic signed [pid_is_pkg::ERR_W-1:0]       err2,
  input  logic signed [pid_is_pkg::INTEG_W-1:0]     integ2,
  input  logic signed [pid_is_pkg::DERIV_W-1:0]     deriv2,
  output logic signed [pid_is_pkg::DRIVE_W-1:0]     drive5
);

  logic signed [pid_is_pkg::PP_W-1:0]  prod_p;
  logic signed [pid_is_pkg::PI_W-1:0]  prod_i;
  logic signed [pid_is_pkg::PD_W-1:0]  prod_d;
  logic signed [pid_is_pkg::ACC_W-1:0] acc;
  logic signed [pid_is_pkg::Q_W-1:0]   q_c;
  logic signed [pid_is_pkg::Q_W-1:0]   olim_c;
  logic signed [pid_is_pkg::Q_W-1:0]   qsat_c;

  // Stage 3: one product per gain.
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      prod_p <= $signed(cfg.gain_p) * err2;
      prod_i <= $signed(cfg.gain_i) * integ2;
      prod_d <= $signed(cfg.gain_d) * deriv2;
    end
  end

  // Stage 4: exact sum with the gain fraction bits.
  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      acc <= pid_is_pkg::ACC_W'(prod_p) + pid_is_pkg::ACC_W'(prod_i) +
             pid_is_pkg::ACC_W'(prod_d);
    end
  end

  // Arithmetic shift rounds toward minus infinity; then clamp symmetrically.
  always_comb begin
    q_c    = pid_is_pkg::Q_W'(acc >>> pid_is_pkg::GAIN_FRAC_BITS);
    olim_c = $signed(pid_is_pkg::Q_W'(cfg.output_limit));
    if (q_c >= olim_c) begin
      qsat_c = olim_c;
    end else if (q_c <= -olim_c) begin
      qsat_c = -olim_c;
    end else begin
      qsat_c = q_c;
    end
  end

  // Stage 5: result register.
  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      drive5 <= qsat_c[pid_is_pkg::DRIVE_W-1:0];
    end
  end

endmodule

// File: sv/pid_controller_integral_separation.sv
// ----------------------------------------------------------------------------
// pid_controller_integral_separation
// PID controller with integral separation, integral clamping and output
// saturation, one sample per word.
// ----------------------------------------------------------------------------
// Usage:
// A sample word (target, measure, rate_of_error) is taken on the input channel
// at a clock edge where in_valid is high and in_stall is low. Each sample gives
// exactly one drive word on the output channel, in order.
// The drive word of a sample passes through the input, state, product, sum and
// result registers in that order before it shows on out_valid.
// Throughput: one sample per cycle while in_stall is low. The integral and
// previous error are updated in the single state stage, so back-to-back samples
// see each other's state. When out_stall is high the result holds and the
// pipeline keeps filling; once all five stages are full, in_stall rises until
// the receiver takes a word.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// sample is in flight; writes to unknown indexes are ignored.
// Reset (rst, synchronous) clears the configuration registers, the integral and
// the previous error, and empties the pipeline.
// ----------------------------------------------------------------------------
module pid_controller_integral_separation (
  input  logic                                      clk,
  input  logic                                      rst,
  // Configuration port.
  input  logic                                      cfg_we,
  input  logic [pid_is_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [pid_is_pkg::CFG_W-1:0]              cfg_data,
  // Input channel.
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [pid_is_pkg::SAMPLE_W-1:0]    target,
  input  logic signed [pid_is_pkg::SAMPLE_W-1:0]    measure,
  input  logic signed [pid_is_pkg::RATE_W-1:0]      rate_of_error,
  // Output channel.
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [pid_is_pkg::DRIVE_W-1:0]     drive
);

  `include "pid_controller_integral_separation_macros.svh"

  pid_is_pkg::cfg_t      cfg;
  pid_is_pkg::pipe_ctl_t ctl;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [pid_is_pkg::SAMPLE_W-1:0] tgt1;
  logic signed [pid_is_pkg::SAMPLE_W-1:0] mea1;
  logic signed [pid_is_pkg::RATE_W-1:0]   rate1;

  logic signed [pid_is_pkg::ERR_W-1:0]    err2;
  logic signed [pid_is_pkg::INTEG_W-1:0]  integ2;
  logic signed [pid_is_pkg::DERIV_W-1:0]  deriv2;
  logic signed [pid_is_pkg::DRIVE_W-1:0]  drive5;

  // A stage can take a word when it is empty or its word moves on.
  always_comb begin
    rdy5 = !v5 || !out_stall;
    rdy4 = !v4 || rdy5;
    rdy3 = !v3 || rdy4;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
    ctl.ld2 = v1 && rdy2;
    ctl.ld3 = v2 && rdy3;
    ctl.ld4 = v3 && rdy4;
    ctl.ld5 = v4 && rdy5;
  end

  assign in_stall  = !rdy1;
  assign out_valid = v5;
  assign drive     = drive5;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      tgt1  <= target;
      mea1  <= measure;
      rate1 <= rate_of_error;
    end
  end

  pid_is_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pid_is_state u_state (
    .clk    (clk),
    .rst    (rst),
    .ld2    (ctl.ld2),
    .cfg    (cfg),
    .tgt    (tgt1),
    .mea    (mea1),
    .rate   (rate1),
    .err2   (err2),
    .integ2 (integ2),
    .deriv2 (deriv2)
  );

  pid_is_mac u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg),
    .err2   (err2),
    .integ2 (integ2),
    .deriv2 (deriv2),
    .drive5 (drive5)
  );

  // An accepted word lands in the input register.
  `PIDIS_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v1, "accepted word lost")
  // The input side stalls only when every stage is full and the output waits.
  `PIDIS_ASSERT_NOW(a_stall_full, in_stall, v1 && v2 && v3 && v4 && v5 && out_stall,
    "input stalled with room in the pipeline")
  // A blocked sum stage keeps its word.
  `PIDIS_ASSERT_NEXT(a_sum_held, v4 && !rdy5, v4, "sum stage word dropped")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// PID controller with integral separation: testbench
// Drives sample words through the controller under several gain, limit, band
// and derivative settings and with random gaps on both channels. Every drive
// word is checked against an in-bench model of the error integral, the
// derivative and the saturated Q8.8 multiply-accumulate.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [pid_is_pkg::REG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int RAND_SETS = 6;
  localparam int WORDS_PER_SET = 125;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [pid_is_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [pid_is_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [pid_is_pkg::SAMPLE_W-1:0] target = '0;
  logic signed [pid_is_pkg::SAMPLE_W-1:0] measure = '0;
  logic signed [pid_is_pkg::RATE_W-1:0] rate_of_error = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pid_is_pkg::DRIVE_W-1:0] drive;

  pid_controller_integral_separation i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .target        (target),
    .measure       (measure),
    .rate_of_error (rate_of_error),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive)
  );

  // One row of the directed sequence: a register write or a sample word.
  typedef struct {
    bit                                     is_cfg;
    logic [pid_is_pkg::REG_IDX_W-1:0]       idx;
    logic [pid_is_pkg::CFG_W-1:0]           data;
    logic signed [pid_is_pkg::SAMPLE_W-1:0] tgt;
    logic signed [pid_is_pkg::SAMPLE_W-1:0] mea;
    logic signed [pid_is_pkg::RATE_W-1:0]   rate;
    bit                                     has_fix;
    logic signed [pid_is_pkg::DRIVE_W-1:0]  fix;
  } stim_row_t;

  stim_row_t directed_rows[$];
  logic signed [pid_is_pkg::DRIVE_W-1:0] drive_due[$];
  logic signed [pid_is_pkg::DRIVE_W-1:0] drive_want;
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Controller settings and state as the model sees them.
  longint kp_q, ki_q, kd_q, int_lim_q, out_lim_q, band_q;
  bit rate_sel_q;
  longint last_err_q, err_sum_q;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Symmetric magnitude clamp; a zero limit forces zero.
  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x >= lim) x = lim;
    if (x <= -lim) x = -lim;
    return x;
  endfunction

  // Mirror of one register write.
  function automatic void apply_reg(input logic [pid_is_pkg::REG_IDX_W-1:0] idx,
                                    input logic [pid_is_pkg::CFG_W-1:0] data);
    case (idx)
      pid_is_pkg::REG_GAIN_P:          kp_q = longint'($signed(data));
      pid_is_pkg::REG_GAIN_I:          ki_q = longint'($signed(data));
      pid_is_pkg::REG_GAIN_D:          kd_q = longint'($signed(data));
      pid_is_pkg::REG_INTEGRAL_LIMIT:  int_lim_q = longint'(data[pid_is_pkg::LIMIT_W-1:0]);
      pid_is_pkg::REG_OUTPUT_LIMIT:    out_lim_q = longint'(data[pid_is_pkg::LIMIT_W-1:0]);
      pid_is_pkg::REG_SEPARATION_BAND: band_q = longint'(data);
      pid_is_pkg::REG_DERIV_SOURCE:    rate_sel_q = data[0];
      default: ;
    endcase
  endfunction

  // Drive word for one sample; advances the integral and the previous error.
  function automatic logic signed [pid_is_pkg::DRIVE_W-1:0] next_drive(
      input logic signed [pid_is_pkg::SAMPLE_W-1:0] t,
      input logic signed [pid_is_pkg::SAMPLE_W-1:0] m,
      input logic signed [pid_is_pkg::RATE_W-1:0] r);
    longint e, mag, s, d, acc, q;
    e = longint'(t) - longint'(m);
    mag = (e < 0) ? -e : e;
    s = err_sum_q + e;
    d = rate_sel_q ? longint'(r) : e - last_err_q;
    last_err_q = e;
    // Large errors drop the integral when the band is enabled.
    if (band_q != 0 && mag > band_q) s = 0;
    s = clamp_mag(s, int_lim_q);
    err_sum_q = s;
    acc = kp_q * e + ki_q * s + kd_q * d;
    q = clamp_mag(acc >>> pid_is_pkg::GAIN_FRAC_BITS, out_lim_q);
    return q[pid_is_pkg::DRIVE_W-1:0];
  endfunction

  function automatic void add_cfg(input logic [pid_is_pkg::REG_IDX_W-1:0] idx,
                                  input logic [pid_is_pkg::CFG_W-1:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_word(input int t, input int m, input int r,
                                   input bit has_fix, input int fix);
    stim_row_t row;
    row = '{default: '0};
    row.tgt = pid_is_pkg::SAMPLE_W'(t);
    row.mea = pid_is_pkg::SAMPLE_W'(m);
    row.rate = pid_is_pkg::RATE_W'(r);
    row.has_fix = has_fix;
    row.fix = pid_is_pkg::DRIVE_W'(fix);
    directed_rows.push_back(row);
  endfunction

  // Register write on the configuration port; the model follows it.
  task automatic write_reg(input logic [pid_is_pkg::REG_IDX_W-1:0] idx,
                           input logic [pid_is_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Offer one sample word, with random idle cycles ahead of it.
  task automatic send_word(input logic signed [pid_is_pkg::SAMPLE_W-1:0] t,
                           input logic signed [pid_is_pkg::SAMPLE_W-1:0] m,
                           input logic signed [pid_is_pkg::RATE_W-1:0] r,
                           input bit has_fix,
                           input logic signed [pid_is_pkg::DRIVE_W-1:0] fix);
    logic signed [pid_is_pkg::DRIVE_W-1:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    target <= t;
    measure <= m;
    rate_of_error <= r;
    do @(posedge clk); while (in_stall);
    want = next_drive(t, m, r);
    drive_due.push_back(has_fix ? fix : want);
  endtask

  // Stop offering words and wait until every drive word has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [pid_is_pkg::CFG_W-1:0] pick_gain();
    if ($urandom_range(1) == 0) return pid_is_pkg::CFG_W'($urandom);
    return pid_is_pkg::CFG_W'($urandom_range(0, 2047) - 1024);
  endfunction

  // Settings for one random phase; the first two are the extremes.
  task automatic configure(input int set_no);
    logic [pid_is_pkg::CFG_W-1:0] band;
    if (set_no == 0) begin
      write_reg(pid_is_pkg::REG_GAIN_P, 16'h7FFF);
      write_reg(pid_is_pkg::REG_GAIN_I, 16'h7FFF);
      write_reg(pid_is_pkg::REG_GAIN_D, 16'h7FFF);
      write_reg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'hFFFF);
      write_reg(pid_is_pkg::REG_OUTPUT_LIMIT, 16'hFFFF);
      write_reg(pid_is_pkg::REG_SEPARATION_BAND, 16'hFFFF);
      write_reg(pid_is_pkg::REG_DERIV_SOURCE, 16'hFFFF);
    end else if (set_no == 1) begin
      write_reg(pid_is_pkg::REG_GAIN_P, 16'h8000);
      write_reg(pid_is_pkg::REG_GAIN_I, 16'h8000);
      write_reg(pid_is_pkg::REG_GAIN_D, 16'h8000);
      write_reg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'h0000);
      write_reg(pid_is_pkg::REG_OUTPUT_LIMIT, 16'h7FFF);
      write_reg(pid_is_pkg::REG_SEPARATION_BAND, 16'h0001);
      write_reg(pid_is_pkg::REG_DERIV_SOURCE, 16'h0000);
    end else begin
      case ($urandom_range(3))
        0: band = '0;
        1: band = pid_is_pkg::CFG_W'($urandom_range(1, 500));
        2: band = pid_is_pkg::CFG_W'($urandom_range(1, 65535));
        default: band = pid_is_pkg::CFG_W'($urandom_range(30000, 65535));
      endcase
      write_reg(pid_is_pkg::REG_GAIN_P, pick_gain());
      write_reg(pid_is_pkg::REG_GAIN_I, pick_gain());
      write_reg(pid_is_pkg::REG_GAIN_D, pick_gain());
      write_reg(pid_is_pkg::REG_INTEGRAL_LIMIT,
                pid_is_pkg::CFG_W'($urandom_range(1) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 2000)));
      write_reg(pid_is_pkg::REG_OUTPUT_LIMIT,
                pid_is_pkg::CFG_W'($urandom_range(1) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 2000)));
      write_reg(pid_is_pkg::REG_SEPARATION_BAND, band);
      write_reg(pid_is_pkg::REG_DERIV_SOURCE, pid_is_pkg::CFG_W'($urandom));
    end
    write_reg(REG_NONE, pid_is_pkg::CFG_W'($urandom));
  endtask

  // Random sample: full range, close pairs, extremes or errors on the band edge.
  task automatic make_word(output logic signed [pid_is_pkg::SAMPLE_W-1:0] t,
                           output logic signed [pid_is_pkg::SAMPLE_W-1:0] m,
                           output logic signed [pid_is_pkg::RATE_W-1:0] r);
    int e, ti, mi;
    case ($urandom_range(3))
      0: begin
        ti = $urandom_range(0, 65535) - 32768;
        mi = $urandom_range(0, 65535) - 32768;
      end
      1: begin
        ti = $urandom_range(0, 60000) - 30000;
        mi = ti + $urandom_range(0, 400) - 200;
      end
      2: begin
        ti = $urandom_range(1) ? 32767 : -32768;
        mi = $urandom_range(1) ? ($urandom_range(1) ? 32767 : -32768) : $urandom_range(1) - 1;
      end
      default: begin
        e = int'(band_q) + $urandom_range(1);
        if (e > 65535) e = 65535;
        if ($urandom_range(1) == 1) e = -e;
        if (e >= 0) begin
          mi = $urandom_range(0, 65535 - e) - 32768;
          ti = mi + e;
        end else begin
          ti = $urandom_range(0, 65535 + e) - 32768;
          mi = ti - e;
        end
      end
    endcase
    t = pid_is_pkg::SAMPLE_W'(ti);
    m = pid_is_pkg::SAMPLE_W'(mi);
    case ($urandom_range(3))
      0, 1: r = pid_is_pkg::RATE_W'($urandom);
      2: r = pid_is_pkg::RATE_W'($urandom_range(0, 200) - 100);
      default: r = $urandom_range(1) ? pid_is_pkg::RATE_W'(65535) : pid_is_pkg::RATE_W'(-65536);
    endcase
  endtask

  // Random stall on the drive channel.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted drive word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_due.size() == 0) begin
        $error("drive: no word expected, got %0d", drive);
        fail_count++;
      end else begin
        drive_want = drive_due.pop_front();
        if (drive !== drive_want) begin
          $error("drive: expected %0d, got %0d", drive_want, drive);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    logic signed [pid_is_pkg::SAMPLE_W-1:0] t, m;
    logic signed [pid_is_pkg::RATE_W-1:0] r;
    kp_q = 0; ki_q = 0; kd_q = 0;
    int_lim_q = 0; out_lim_q = 0; band_q = 0; rate_sel_q = 1'b0;
    last_err_q = 0; err_sum_q = 0;

    // All gains and limits are zero after reset.
    add_word(32767, -32768, -65536, 1, 0);
    add_word(-32768, 32767, 65535, 1, 0);
    // Unity proportional gain, full limits.
    add_cfg(pid_is_pkg::REG_GAIN_P, 16'h0100);
    add_cfg(pid_is_pkg::REG_OUTPUT_LIMIT, 16'h7FFF);
    add_cfg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'h7FFF);
    add_word(100, 40, 0, 1, 60);
    add_word(-32768, 32767, 0, 1, -32767);
    // Half gain: the shift rounds toward minus infinity.
    add_cfg(pid_is_pkg::REG_GAIN_P, 16'h0080);
    add_word(-1, 0, 0, 1, -1);
    add_word(1, 0, 0, 1, 0);
    add_word(0, 3, 0, 1, -2);
    add_cfg(pid_is_pkg::REG_GAIN_P, 16'h8000);
    add_word(32767, -32768, 0, 1, -32767);
    // Integral only, with a separation band of 50.
    add_cfg(pid_is_pkg::REG_GAIN_P, 16'h0000);
    add_cfg(pid_is_pkg::REG_GAIN_I, 16'h0100);
    add_cfg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'd100);
    add_cfg(pid_is_pkg::REG_SEPARATION_BAND, 16'd50);
    add_word(50, 0, 0, 1, 100);
    add_word(51, 0, 0, 1, 0);
    add_word(-50, 0, 0, 1, -50);
    add_word(20, -30, 0, 0, 0);
    add_word(-25, 26, 0, 0, 0);
    // A zero integral limit holds the integral at zero.
    add_cfg(pid_is_pkg::REG_SEPARATION_BAND, 16'd0);
    add_cfg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'd0);
    add_word(1000, 0, 0, 1, 0);
    // Derivative from the error difference, widest swing.
    add_cfg(pid_is_pkg::REG_GAIN_I, 16'h0000);
    add_cfg(pid_is_pkg::REG_INTEGRAL_LIMIT, 16'h7FFF);
    add_cfg(pid_is_pkg::REG_GAIN_D, 16'h0100);
    add_cfg(pid_is_pkg::REG_DERIV_SOURCE, 16'd0);
    add_word(32767, -32768, 0, 0, 0);
    add_word(-32768, 32767, 0, 1, -32767);
    // External rate; the previous error still follows the samples.
    add_cfg(pid_is_pkg::REG_GAIN_D, 16'h0040);
    add_cfg(pid_is_pkg::REG_DERIV_SOURCE, 16'd1);
    add_word(0, 0, -65536, 1, -16384);
    add_word(5, 5, 65535, 1, 16383);
    add_word(7, 3, -3, 0, 0);
    add_cfg(pid_is_pkg::REG_DERIV_SOURCE, 16'd0);
    add_word(10, 3, 0, 0, 0);
    // Writes to an unused index change nothing.
    add_cfg(REG_NONE, 16'hFFFF);
    add_word(300, 0, 0, 0, 0);
    // A zero output limit forces the drive to zero.
    add_cfg(pid_is_pkg::REG_OUTPUT_LIMIT, 16'd0);
    add_word(32767, -32768, 65535, 1, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        drain();
        write_reg(directed_rows[k].idx, directed_rows[k].data);
      end else begin
        send_word(directed_rows[k].tgt, directed_rows[k].mea, directed_rows[k].rate,
                  directed_rows[k].has_fix, directed_rows[k].fix);
      end
    end

    // Random phases: each with its own settings and idling pattern.
    for (int s = 0; s < RAND_SETS; s++) begin
      drain();
      configure(s);
      send_idle_pct = (s % 4 == 1) ? 87 : (s % 4 == 3) ? 20 : 0;
      stall_pct = (s % 4 == 2) ? 87 : (s % 4 == 3) ? 20 : 0;
      repeat (WORDS_PER_SET) begin
        make_word(t, m, r);
        send_word(t, m, r, 1'b0, '0);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
